// File: rtl/core/tccs_pkg.sv
package tccs_pkg;

   // Field widths of the request and response channels
   localparam int COMMAND_W    = 2;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int CELL_ADDR_W  = 11;
   localparam int COLUMN_OUT_W = 7;
   localparam int ROW_OUT_W    = 5;
   localparam int OFFSET_W     = 11;

   // Request command codes
   localparam logic [COMMAND_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_READ  = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_CLEAR = 2'd2;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

   // Start point of a store sweep
   typedef enum logic [1:0] {
      SWEEP_ZERO,
      SWEEP_COPY,
      SWEEP_LAST_ROW
   } sweep_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic          load_req;
      logic          exec_put;
      logic          read_issue;
      logic          cursor_home;
      logic          sweep_load;
      sweep_sel_type sweep_sel;
      logic          sweep_step;
      logic          fill_write;
      logic          fill_attr_zero;
      logic          full_range;
      logic          copy_read;
      logic          out_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic                 will_scroll;
      logic                 sweep_last;
   } dp_status_type;

endpackage

// File: rtl/core/tccs_req_if.sv
interface tccs_req_if;
   import tccs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [COMMAND_W-1:0]   command;
   logic [CHAR_W-1:0]      char_code;
   logic [CELL_ADDR_W-1:0] cell_address;

   modport source (output valid, output command, output char_code, output cell_address,
                   input ready);
   modport sink   (input valid, input command, input char_code, input cell_address,
                   output ready);
endinterface

// File: rtl/core/tccs_rsp_if.sv
interface tccs_rsp_if;
   import tccs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [COLUMN_OUT_W-1:0] cursor_column;
   logic [ROW_OUT_W-1:0]    cursor_row;
   logic [OFFSET_W-1:0]     cursor_offset;
   logic [CHAR_W-1:0]       read_char;
   logic [ATTR_W-1:0]       read_attr;
   logic                    scrolled;

   modport source (output valid, output cursor_column, output cursor_row,
                   output cursor_offset, output read_char, output read_attr,
                   output scrolled, input ready);
   modport sink   (input valid, input cursor_column, input cursor_row,
                   input cursor_offset, input read_char, input read_attr,
                   input scrolled, output ready);
endinterface

// File: rtl/core/text_console_cursor_scroll.sv
// Text console with a COLUMNS x ROWS character and attribute store and a cursor. After
// reset the store is swept to zero, one cell a cycle, and no request is taken until that
// is done; csr writes are taken at any time. A put character, read cell or unused command
// goes through the capture, execute and response-load steps before the next request is
// taken; the response load waits while an earlier response is still stalled. Clear screen
// homes the cursor and blanks every row but the bottom one, cell by cell. A put that
// scrolls then moves the rows up one cell a cycle through the store's read and write
// ports, lets the last copy write land, then blanks the row above the bottom cell by cell.
// One request is processed at a time; a new one is taken while the previous response waits.
module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   tccs_req_if.sink                    req_bus,
   tccs_rsp_if.source                  rsp_bus,
   input  logic                        csr_write_enable,
   input  logic [tccs_pkg::ATTR_W-1:0] csr_write_data
);
   import tccs_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tccs_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   tccs_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_bus.command),
      .req_char_code     (req_bus.char_code),
      .req_cell_address  (req_bus.cell_address),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .rsp_cursor_column (rsp_bus.cursor_column),
      .rsp_cursor_row    (rsp_bus.cursor_row),
      .rsp_cursor_offset (rsp_bus.cursor_offset),
      .rsp_read_char     (rsp_bus.read_char),
      .rsp_read_attr     (rsp_bus.read_attr),
      .rsp_scrolled      (rsp_bus.scrolled)
   );

endmodule

// File: rtl/core/tccs_control.sv
module tccs_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tccs_pkg::dp_cmd_type    dp_cmd,
   input  tccs_pkg::dp_status_type dp_status
);
   import tccs_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_COPY,
      S_DRAIN,
      S_FILL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      dp_cmd       = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_INIT: begin
            // clear the whole store after reset
            dp_cmd.fill_write     = 1'b1;
            dp_cmd.fill_attr_zero = 1'b1;
            dp_cmd.full_range     = 1'b1;
            dp_cmd.sweep_step     = 1'b1;
            if (dp_status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (dp_status.command)
               CMD_PUT: begin
                  dp_cmd.exec_put = 1'b1;
                  if (dp_status.will_scroll) begin
                     dp_cmd.sweep_load = 1'b1;
                     dp_cmd.sweep_sel  = SWEEP_COPY;
                     state_in          = S_COPY;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               CMD_READ: begin
                  dp_cmd.read_issue = 1'b1;
                  state_in          = S_DONE;
               end
               CMD_CLEAR: begin
                  dp_cmd.cursor_home = 1'b1;
                  dp_cmd.sweep_load  = 1'b1;
                  dp_cmd.sweep_sel   = SWEEP_ZERO;
                  state_in           = S_FILL;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_COPY: begin
            // move rows up by one, one cell a cycle
            dp_cmd.copy_read  = 1'b1;
            dp_cmd.sweep_step = 1'b1;
            if (dp_status.sweep_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last copy write lands here; then blank the row above the bottom
            dp_cmd.sweep_load = 1'b1;
            dp_cmd.sweep_sel  = SWEEP_LAST_ROW;
            state_in          = S_FILL;
         end
         S_FILL: begin
            dp_cmd.fill_write = 1'b1;
            dp_cmd.sweep_step = 1'b1;
            if (dp_status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.out_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/tccs_datapath.sv
module tccs_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tccs_pkg::COMMAND_W-1:0]    req_command,
   input  logic [tccs_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tccs_pkg::CELL_ADDR_W-1:0]  req_cell_address,
   input  logic                              csr_write_enable,
   input  logic [tccs_pkg::ATTR_W-1:0]       csr_write_data,
   input  tccs_pkg::dp_cmd_type              dp_cmd,
   output tccs_pkg::dp_status_type           dp_status,
   output logic [tccs_pkg::COLUMN_OUT_W-1:0] rsp_cursor_column,
   output logic [tccs_pkg::ROW_OUT_W-1:0]    rsp_cursor_row,
   output logic [tccs_pkg::OFFSET_W-1:0]     rsp_cursor_offset,
   output logic [tccs_pkg::CHAR_W-1:0]       rsp_read_char,
   output logic [tccs_pkg::ATTR_W-1:0]       rsp_read_attr,
   output logic                              rsp_scrolled
);
   import tccs_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int CMP_W = ((AW > CELL_ADDR_W) ? AW : CELL_ADDR_W) + 1;

   localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_ALL      = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_TEXT     = AW'(COLUMNS * (ROWS - 1) - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'(COLUMNS * (ROWS - 2));
   localparam logic [CW:0]   COLS_C        = (CW+1)'(COLUMNS);
   localparam logic [RW-1:0] ROW_LIMIT     = RW'(ROWS - 1);

   // Store
   logic [CHAR_W-1:0] char_mem [CELLS];
   logic [ATTR_W-1:0] attr_mem [CELLS];

   // Request capture
   logic [COMMAND_W-1:0]   command_ff;
   logic [CHAR_W-1:0]      char_ff;
   logic [CELL_ADDR_W-1:0] addr_ff;

   logic [CW-1:0]     col_ff;
   logic [RW-1:0]     row_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [AW-1:0]     sweep_ff;
   logic              copy_pend_ff;
   logic [AW-1:0]     copy_dest_ff;
   logic [CHAR_W-1:0] rd_char_ff;
   logic [ATTR_W-1:0] rd_attr_ff;
   logic              scrolled_ff;

   logic [COLUMN_OUT_W-1:0] out_col_ff;
   logic [ROW_OUT_W-1:0]    out_row_ff;
   logic [OFFSET_W-1:0]     out_off_ff;
   logic [CHAR_W-1:0]       out_char_ff;
   logic [ATTR_W-1:0]       out_attr_ff;
   logic                    out_scrolled_ff;

   logic [AW-1:0]     row_base;
   logic [AW-1:0]     cur_pos;
   logic [CW:0]       col_inc;
   logic [CW-1:0]     col_next;
   logic [RW-1:0]     row_next;
   logic [RW-1:0]     row_final;
   logic              will_scroll;
   logic              put_we_char;
   logic              put_we_attr;
   logic [AW-1:0]     put_addr;
   logic [CHAR_W-1:0] put_char;
   logic              addr_ok;
   logic              sweep_last;

   logic              mem_we_char;
   logic              mem_we_attr;
   logic [AW-1:0]     mem_waddr;
   logic [CHAR_W-1:0] mem_wchar;
   logic [ATTR_W-1:0] mem_wattr;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;

   // Request capture and scroll flag
   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         command_ff  <= req_command;
         char_ff     <= req_char_code;
         addr_ff     <= req_cell_address;
         scrolled_ff <= 1'b0;
      end else if (dp_cmd.exec_put) begin
         scrolled_ff <= will_scroll;
      end
   end

   // Text attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   // Cursor position and character handling
   always_comb begin
      row_base    = AW'(row_ff) * COLS_A;
      cur_pos     = row_base + AW'(col_ff);
      col_inc     = (CW+1)'(col_ff) + (CW+1)'(1);
      col_next    = col_ff;
      row_next    = row_ff;
      put_we_char = 1'b0;
      put_we_attr = 1'b0;
      put_addr    = cur_pos;
      put_char    = char_ff;
      if (char_ff == CH_BACKSPACE) begin
         // step back and blank the character, attribute stays
         if (col_ff != '0) begin
            col_next    = col_ff - CW'(1);
            put_addr    = cur_pos - AW'(1);
            put_char    = '0;
            put_we_char = 1'b1;
         end
      end else if (char_ff == CH_CR) begin
         col_next = '0;
      end else if (char_ff == CH_LF) begin
         col_next = '0;
         row_next = row_ff + RW'(1);
      end else begin
         put_we_char = 1'b1;
         put_we_attr = 1'b1;
         if (col_inc == COLS_C) begin
            col_next = '0;
            row_next = row_ff + RW'(1);
         end else begin
            col_next = col_inc[CW-1:0];
         end
      end
      will_scroll = (row_next == ROW_LIMIT);
      row_final   = will_scroll ? (row_next - RW'(1)) : row_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (dp_cmd.cursor_home) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (dp_cmd.exec_put) begin
         col_ff <= col_next;
         row_ff <= row_final;
      end
   end

   // Sweep counter for clearing and scrolling
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (dp_cmd.sweep_load) begin
         case (dp_cmd.sweep_sel)
            SWEEP_COPY:     sweep_ff <= COLS_A;
            SWEEP_LAST_ROW: sweep_ff <= LAST_ROW_BASE;
            default:        sweep_ff <= '0;
         endcase
      end else if (dp_cmd.sweep_step) begin
         sweep_ff <= sweep_ff + AW'(1);
      end
   end

   assign sweep_last = (sweep_ff == (dp_cmd.full_range ? LAST_ALL : LAST_TEXT));

   // Copy write lands in the cycle after the read, one row lower in address
   always_ff @(posedge clock) begin
      if (reset) begin
         copy_pend_ff <= 1'b0;
      end else begin
         copy_pend_ff <= dp_cmd.copy_read;
      end
   end

   always_ff @(posedge clock) begin
      copy_dest_ff <= sweep_ff - COLS_A;
   end

   assign addr_ok = (CMP_W'(addr_ff) < CMP_W'(CELLS));

   // Store write port
   always_comb begin
      mem_we_char = 1'b0;
      mem_we_attr = 1'b0;
      mem_waddr   = sweep_ff;
      mem_wchar   = '0;
      mem_wattr   = dp_cmd.fill_attr_zero ? '0 : attr_ff;
      if (copy_pend_ff) begin
         mem_we_char = 1'b1;
         mem_we_attr = 1'b1;
         mem_waddr   = copy_dest_ff;
         mem_wchar   = rd_char_ff;
         mem_wattr   = rd_attr_ff;
      end else if (dp_cmd.fill_write) begin
         mem_we_char = 1'b1;
         mem_we_attr = 1'b1;
      end else if (dp_cmd.exec_put) begin
         mem_we_char = put_we_char;
         mem_we_attr = put_we_attr;
         mem_waddr   = put_addr;
         mem_wchar   = put_char;
         mem_wattr   = attr_ff;
      end
   end

   // Store read port
   assign mem_re    = dp_cmd.copy_read || (dp_cmd.read_issue && addr_ok);
   assign mem_raddr = dp_cmd.copy_read ? sweep_ff : AW'(addr_ff);

   always_ff @(posedge clock) begin
      if (mem_we_char) begin
         char_mem[mem_waddr] <= mem_wchar;
      end
      if (mem_we_attr) begin
         attr_mem[mem_waddr] <= mem_wattr;
      end
      if (mem_re) begin
         rd_char_ff <= char_mem[mem_raddr];
         rd_attr_ff <= attr_mem[mem_raddr];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         out_col_ff      <= COLUMN_OUT_W'(col_ff);
         out_row_ff      <= ROW_OUT_W'(row_ff);
         out_off_ff      <= OFFSET_W'(cur_pos);
         out_scrolled_ff <= scrolled_ff;
         if ((command_ff == CMD_READ) && addr_ok) begin
            out_char_ff <= rd_char_ff;
            out_attr_ff <= rd_attr_ff;
         end else begin
            out_char_ff <= '0;
            out_attr_ff <= '0;
         end
      end
   end

   assign dp_status.command     = command_ff;
   assign dp_status.will_scroll = will_scroll;
   assign dp_status.sweep_last  = sweep_last;

   assign rsp_cursor_column = out_col_ff;
   assign rsp_cursor_row    = out_row_ff;
   assign rsp_cursor_offset = out_off_ff;
   assign rsp_read_char     = out_char_ff;
   assign rsp_read_attr     = out_attr_ff;
   assign rsp_scrolled      = out_scrolled_ff;

endmodule

// File: rtl/core/tccs_checker.sv
module tccs_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tccs_pkg::COLUMN_OUT_W-1:0] rsp_cursor_column,
   input logic [tccs_pkg::ROW_OUT_W-1:0]    rsp_cursor_row,
   input logic [tccs_pkg::OFFSET_W-1:0]     rsp_cursor_offset,
   input logic [tccs_pkg::CHAR_W-1:0]       rsp_read_char,
   input logic [tccs_pkg::ATTR_W-1:0]       rsp_read_attr,
   input logic                              rsp_scrolled
);
   import tccs_pkg::*;

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_cursor_column, rsp_cursor_row, rsp_cursor_offset,
                  rsp_read_char, rsp_read_attr, rsp_scrolled}))
      else $error("response changed while stalled");

   // One request at a time: no acceptance right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Offset matches the reported cursor when neither field is truncated
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (COLUMNS > 128 || ROWS > 33 ||
         rsp_cursor_offset == OFFSET_W'(int'(rsp_cursor_row) * COLUMNS
                                        + int'(rsp_cursor_column))))
      else $error("cursor offset does not match cursor");

   // After a scroll the cursor sits on the row above the bottom
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_row == ROW_OUT_W'(ROWS - 2))
      else $error("scroll left cursor on wrong row");

endmodule

bind text_console_cursor_scroll tccs_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tccs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_cursor_column (rsp_bus.cursor_column),
   .rsp_cursor_row    (rsp_bus.cursor_row),
   .rsp_cursor_offset (rsp_bus.cursor_offset),
   .rsp_read_char     (rsp_bus.read_char),
   .rsp_read_attr     (rsp_bus.read_attr),
   .rsp_scrolled      (rsp_bus.scrolled)
);

// File: sim/tb.sv
module tb;
   import tccs_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Command code that the block leaves alone
   localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

   // Longest stretch without any request or response moving
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 315;

   typedef struct {
      logic [COLUMN_OUT_W-1:0] column;
      logic [ROW_OUT_W-1:0]    row;
      logic [OFFSET_W-1:0]     offset;
      logic [CHAR_W-1:0]       rd_char;
      logic [ATTR_W-1:0]       rd_attr;
      logic                    scrolled;
   } cursor_report_type;

   // Screen and cursor tracker; one expected cursor report per accepted request
   class console_scoreboard;
      logic [CHAR_W-1:0] char_mem [CELLS];
      logic [ATTR_W-1:0] attr_mem [CELLS];
      int                cur_col;
      int                cur_row;
      logic [ATTR_W-1:0] attribute;
      cursor_report_type report_q [$];
      int                error_count;

      function new();
         foreach (char_mem[i]) begin
            char_mem[i] = '0;
            attr_mem[i] = '0;
         end
         cur_col     = 0;
         cur_row     = 0;
         attribute   = ATTR_RESET;
         error_count = 0;
      endfunction

      function void set_attribute(logic [ATTR_W-1:0] value);
         attribute = value;
      endfunction

      function int pending();
         return report_q.size();
      endfunction

      // Blank rows first .. stop-1 with the current attribute
      function void blank_rows(int first, int stop);
         for (int i = first * COLUMNS; i < stop * COLUMNS && i < CELLS; i++) begin
            char_mem[i] = '0;
            attr_mem[i] = attribute;
         end
      endfunction

      // Move the screen up one row; bottom row keeps its old content
      function void shift_screen_up();
         for (int i = 0; i < COLUMNS * (ROWS - 1); i++) begin
            char_mem[i] = char_mem[i + COLUMNS];
            attr_mem[i] = attr_mem[i + COLUMNS];
         end
         blank_rows(ROWS - 2, ROWS - 1);
         if (cur_row == 0) begin
            cur_col = 0;
         end else begin
            cur_row = cur_row - 1;
         end
      endfunction

      // Returns 1 when the character pushed the cursor into a scroll
      function bit emit_char(logic [CHAR_W-1:0] c);
         int pos;
         if (c == CH_BACKSPACE) begin
            if (cur_col > 0) begin
               cur_col = cur_col - 1;
               pos = cur_row * COLUMNS + cur_col;
               if (pos < CELLS) char_mem[pos] = '0;
            end
         end else if (c == CH_CR) begin
            cur_col = 0;
         end else if (c == CH_LF) begin
            cur_col = 0;
            cur_row = cur_row + 1;
         end else begin
            pos = cur_row * COLUMNS + cur_col;
            if (pos < CELLS) begin
               char_mem[pos] = c;
               attr_mem[pos] = attribute;
            end
            cur_col = cur_col + 1;
         end
         if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row = cur_row + 1;
         end
         if (cur_row >= ROWS - 1) begin
            shift_screen_up();
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [COMMAND_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                 logic [CELL_ADDR_W-1:0] addr);
         cursor_report_type exp;
         int                offs;
         exp.rd_char  = '0;
         exp.rd_attr  = '0;
         exp.scrolled = 1'b0;
         case (cmd)
            CMD_PUT: begin
               exp.scrolled = emit_char(ch);
            end
            CMD_READ: begin
               if (addr < CELLS) begin
                  exp.rd_char = char_mem[addr];
                  exp.rd_attr = attr_mem[addr];
               end
            end
            CMD_CLEAR: begin
               blank_rows(0, ROWS - 1);
               cur_col = 0;
               cur_row = 0;
            end
            default: begin
            end
         endcase
         offs       = cur_row * COLUMNS + cur_col;
         exp.column = cur_col[COLUMN_OUT_W-1:0];
         exp.row    = cur_row[ROW_OUT_W-1:0];
         exp.offset = offs[OFFSET_W-1:0];
         report_q.push_back(exp);
      endfunction

      function void check_response(cursor_report_type got);
         cursor_report_type exp;
         if (report_q.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
            return;
         end
         exp = report_q.pop_front();
         if (got.column !== exp.column) begin
            $error("cursor_column: expected %0d, got %0d", exp.column, got.column);
            error_count++;
         end
         if (got.row !== exp.row) begin
            $error("cursor_row: expected %0d, got %0d", exp.row, got.row);
            error_count++;
         end
         if (got.offset !== exp.offset) begin
            $error("cursor_offset: expected %0d, got %0d", exp.offset, got.offset);
            error_count++;
         end
         if (got.rd_char !== exp.rd_char) begin
            $error("read_char: expected %0h, got %0h", exp.rd_char, got.rd_char);
            error_count++;
         end
         if (got.rd_attr !== exp.rd_attr) begin
            $error("read_attr: expected %0h, got %0h", exp.rd_attr, got.rd_attr);
            error_count++;
         end
         if (got.scrolled !== exp.scrolled) begin
            $error("scrolled: expected %0b, got %0b", exp.scrolled, got.scrolled);
            error_count++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [ATTR_W-1:0] csr_write_data;

   tccs_req_if req_bus ();
   tccs_rsp_if rsp_bus ();

   console_scoreboard sb = new();

   int  requests_sent   = 0;
   int  idle_cycles     = 0;
   int  rsp_hold_cycles = 0;
   bit  snd_calm        = 1'b0;
   bit  rsp_calm        = 1'b0;

   text_console_cursor_scroll #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   // Response side: random backpressure, plus a long hold-off on demand
   initial begin : rsp_side
      int stall;
      int hold;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall = rsp_calm ? 0 : pick_gap();
         end
      end
   end

   // Sample both channels at the rising edge; watchdog on lack of progress
   always @(posedge clock) begin : monitor
      cursor_report_type got;
      bit                moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.column   = rsp_bus.cursor_column;
            got.row      = rsp_bus.cursor_row;
            got.offset   = rsp_bus.cursor_offset;
            got.rd_char  = rsp_bus.read_char;
            got.rd_attr  = rsp_bus.read_attr;
            got.scrolled = rsp_bus.scrolled;
            sb.check_response(got);
            moved = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.command, req_bus.char_code, req_bus.cell_address);
            moved = 1'b1;
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("FAIL text_console_cursor_scroll");
               $finish;
            end
         end
      end
   end

   // Offer one request; called just after a falling edge, returns at one
   task automatic send_req(input logic [COMMAND_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [CELL_ADDR_W-1:0] addr);
      int gap;
      gap = snd_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.char_code    <= ch;
      req_bus.cell_address <= addr;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      if (cmd != CMD_UNUSED) requests_sent++;
      @(negedge clock);
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] c);
      logic [CELL_ADDR_W-1:0] junk;
      junk = CELL_ADDR_W'($urandom_range(0, 2047));
      send_req(CMD_PUT, c, junk);
   endtask

   task automatic read_cell(input logic [CELL_ADDR_W-1:0] addr);
      logic [CHAR_W-1:0] junk;
      junk = CHAR_W'($urandom_range(0, 255));
      send_req(CMD_READ, junk, addr);
   endtask

   task automatic clear_screen();
      logic [CHAR_W-1:0]      junk_c;
      logic [CELL_ADDR_W-1:0] junk_a;
      junk_c = CHAR_W'($urandom_range(0, 255));
      junk_a = CELL_ADDR_W'($urandom_range(0, 2047));
      send_req(CMD_CLEAR, junk_c, junk_a);
   endtask

   // Stop offering and wait until every response is back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_attr(input logic [ATTR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_attribute(value);
      @(negedge clock);
   endtask

   // Random traffic built from text-like sequences with some noise mixed in
   task automatic run_random(input int count);
      int                     target;
      int                     kind;
      int                     len;
      int                     r;
      logic [CHAR_W-1:0]      c;
      logic [CELL_ADDR_W-1:0] a;
      logic [COMMAND_W-1:0]   cmd;
      target = requests_sent + count;
      while (requests_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // line of text, sometimes long enough to wrap
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
            repeat (len) begin
               if ($urandom_range(0, 6) == 0) c = CHAR_W'($urandom_range(0, 255));
               else c = CHAR_W'($urandom_range(8'h20, 8'h7E));
               put_char(c);
            end
            r = $urandom_range(0, 9);
            if (r < 5) put_char(CH_LF);
            else if (r < 7) put_char(CH_CR);
         end else if (kind < 50) begin
            // line feeds, sometimes enough to reach the bottom
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
            repeat (len) put_char(CH_LF);
         end else if (kind < 60) begin
            // backspaces, then look at the cell under the cursor
            len = $urandom_range(1, 10);
            repeat (len) put_char(CH_BACKSPACE);
            read_cell(CELL_ADDR_W'(sb.cur_row * COLUMNS + sb.cur_col));
         end else if (kind < 75) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               r = $urandom_range(0, 9);
               if (r < 5) a = CELL_ADDR_W'($urandom_range(0, 2047));
               else if (r < 8) a = CELL_ADDR_W'(sb.cur_row * COLUMNS
                                                 + $urandom_range(0, COLUMNS - 1));
               else a = CELL_ADDR_W'($urandom_range((ROWS - 2) * COLUMNS, CELLS - 1));
               read_cell(a);
            end
         end else if (kind < 85) begin
            // noise: mostly the unused code, fields fully random
            len = $urandom_range(1, 3);
            repeat (len) begin
               if ($urandom_range(0, 9) < 7) cmd = CMD_UNUSED;
               else cmd = COMMAND_W'($urandom_range(0, 3));
               c = CHAR_W'($urandom_range(0, 255));
               a = CELL_ADDR_W'($urandom_range(0, 2047));
               send_req(cmd, c, a);
            end
         end else if (kind < 88) begin
            clear_screen();
         end else begin
            // overwrite the current line after a carriage return
            put_char(CH_CR);
            len = $urandom_range(1, 12);
            repeat (len) begin
               c = CHAR_W'($urandom_range(0, 255));
               put_char(c);
            end
         end
      end
   endtask

   initial begin : main
      logic [ATTR_W-1:0] attr_val;
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_PUT;
      req_bus.char_code    = '0;
      req_bus.cell_address = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset attribute
      put_char(CH_BACKSPACE);          // backspace at column zero
      put_char(8'h48);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h7F);
      put_char(CH_BACKSPACE);          // clears char only, attribute stays
      read_cell(11'd3);
      read_cell(11'd0);
      read_cell(11'd2);
      put_char(CH_CR);
      put_char(CH_LF);
      read_cell(11'd1999);
      read_cell(11'd2000);             // past the store
      read_cell(11'h7FF);
      send_req(CMD_UNUSED, 8'hFF, 11'h7FF);
      send_req(CMD_UNUSED, 8'h00, 11'h000);
      clear_screen();
      read_cell(11'd0);
      read_cell(11'(CELLS - COLUMNS)); // bottom row is left alone by clear
      put_char(8'h55);
      put_char(8'hAA);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: attr_val = 8'h00;
            1: attr_val = 8'hFF;
            3: attr_val = 8'h80;
            4: attr_val = 8'h01;
            default: attr_val = ATTR_W'($urandom_range(1, 254));
         endcase
         write_attr(attr_val);
         snd_calm = 1'b0;
         rsp_calm = 1'b0;
         if (phase == 1) begin
            // receiver holds off while requests keep coming
            snd_calm = 1'b1;
            rsp_hold_cycles = 300;
            run_random(60);
            snd_calm = 1'b0;
            run_random(PHASE_ITEMS - 60);
         end else if (phase == 2) begin
            snd_calm = 1'b1;
            rsp_calm = 1'b1;
            run_random(PHASE_ITEMS);
         end else if (phase == 3) begin
            run_random(PHASE_ITEMS / 2);
            wait_drained();
            run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_random(PHASE_ITEMS);
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("PASS text_console_cursor_scroll");
      end else begin
         $display("FAIL text_console_cursor_scroll");
      end
      $finish;
   end

endmodule
